[rtl/core/tgbc_pkg.sv]
package tgbc_pkg;

  // fixed field widths
  localparam int CELL_IDX_W = 7;
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 20;
  localparam int SIZE_W     = 16;
  localparam int FRAC_W     = 8;

  // neighborhood searched around the snapped corner cell
  localparam int LOOK_X = 2;
  localparam int LOOK_Y = 1;

  // divide-by-cell unit: biased operand, quotient and cell index widths
  localparam int DIV_IN_W  = 22;
  localparam int DIV_N     = 13;
  localparam int DIV_OUT_W = 14;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]                mode;
    logic [CELL_IDX_W-1:0]     cell_x;
    logic [CELL_IDX_W-1:0]     cell_y;
    logic [KIND_W-1:0]         tile_kind;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] read_kind;
    logic              hit;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_DIV_SNAP,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_DIV_WAIT,
    ST_WINDOW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RAM_IDLE,
    RAM_CLEAR,
    RAM_WRITE,
    RAM_READ_CELL,
    RAM_READ_SCAN
  } ram_op_e;

  typedef enum logic [1:0] {
    DIV_SNAP,
    DIV_LO,
    DIV_HI
  } div_op_e;

  typedef struct packed {
    logic    take;
    ram_op_e ram_op;
    logic    div_go;
    div_op_e div_op;
    logic    win_load;
    logic    kind_cap;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic win_empty;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/tgbc_ram.sv]
module tgbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tgbc_cdiv.sv]
module tgbc_cdiv import tgbc_pkg::*; #(
  parameter int TILE_PITCH = 16
) (
  input  logic                        clk_i,
  input  logic signed [DIV_IN_W-1:0]  val_i,
  output logic signed [DIV_OUT_W-1:0] cell_o
);

  // one cell spans TILE_PITCH world units in 8-bit fixed point
  localparam int CELL_FIX = TILE_PITCH << FRAC_W;
  // bias in whole cells that lifts every operand above zero
  localparam int OFS_Q    = ((1 << (COORD_W - 1)) + CELL_FIX) / CELL_FIX;
  localparam int OFS      = OFS_Q * CELL_FIX;
  // exact reciprocal for a DIV_N-bit numerator
  localparam int LS       = $clog2(TILE_PITCH);
  localparam int SH       = DIV_N + LS;
  localparam int MUL      = ((1 << SH) + TILE_PITCH - 1) / TILE_PITCH;
  localparam int MUL_W    = DIV_N + 2;
  localparam int PROD_W   = DIV_N + MUL_W;

  logic signed [DIV_IN_W-1:0] biased;
  logic [DIV_N-1:0]           num;
  logic [PROD_W-1:0]          prod_d, prod_q;
  logic [DIV_N-1:0]           quot;

  // bias, drop the fraction bits, multiply by the reciprocal
  always_comb begin
    biased = val_i + DIV_IN_W'(OFS);
    num    = biased[FRAC_W +: DIV_N];
    prod_d = PROD_W'(num) * PROD_W'(MUL);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor quotient, bias removed
  assign quot   = DIV_N'(prod_q >> SH);
  assign cell_o = $signed({1'b0, quot}) - DIV_OUT_W'(OFS_Q);

endmodule

[rtl/core/tgbc_dpath.sv]
module tgbc_dpath import tgbc_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int TILE_PITCH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  ctl_cmd_t  cmd_i,
  output dp_sts_t   sts_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_o
);

  localparam int XW      = $clog2(MAP_WIDTH);
  localparam int YW      = $clog2(MAP_HEIGHT);
  localparam int AW      = XW + YW;
  localparam int DEPTH   = MAP_HEIGHT << XW;
  localparam int HALF_M1 = (TILE_PITCH << (FRAC_W - 1)) - 1;

  typedef logic signed [DIV_OUT_W-1:0] cidx_t;

  function automatic cidx_t smax(input cidx_t a, input cidx_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic cidx_t smin(input cidx_t a, input cidx_t b);
    return (a < b) ? a : b;
  endfunction

  in_item_t          item_q;
  logic              cell_ok;
  logic [AW-1:0]     cell_addr;

  logic signed [DIV_IN_W-1:0] left_ext, top_ext, wid_ext, hgt_ext;
  logic signed [DIV_IN_W-1:0] x_val, y_val;
  cidx_t             x_cell, y_cell;
  logic              div_pend_q;
  div_op_e           div_op_q;
  cidx_t             cx_q, lox_q, hix_q, cy_q, loy_q, hiy_q;

  cidx_t             xs, xe, ys, ye;
  logic              empty;
  logic [XW-1:0]     x_q, xs_q, xe_q;
  logic [YW-1:0]     y_q, ye_q;

  logic [AW-1:0]     clr_q;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [KIND_W-1:0] ram_wdata, ram_rdata;
  logic              chk_q;

  logic [KIND_W-1:0] kind_q;
  logic              hit_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= in_i;
    end
  end

  assign cell_ok = (11'(item_q.cell_x) < 11'(MAP_WIDTH)) &&
                   (11'(item_q.cell_y) < 11'(MAP_HEIGHT));
  assign cell_addr = {YW'(item_q.cell_y), XW'(item_q.cell_x)};

  // operand select for the two divide units
  always_comb begin
    left_ext = DIV_IN_W'(item_q.box_left);
    top_ext  = DIV_IN_W'(item_q.box_top);
    wid_ext  = DIV_IN_W'(item_q.box_width);
    hgt_ext  = DIV_IN_W'(item_q.box_height);
    case (cmd_i.div_op)
      DIV_SNAP: begin
        x_val = left_ext + DIV_IN_W'(HALF_M1);
        y_val = top_ext + DIV_IN_W'(HALF_M1);
      end
      DIV_HI: begin
        x_val = left_ext + wid_ext - DIV_IN_W'(1);
        y_val = top_ext + hgt_ext - DIV_IN_W'(1);
      end
      default: begin
        x_val = left_ext;
        y_val = top_ext;
      end
    endcase
  end

  tgbc_cdiv #(.TILE_PITCH(TILE_PITCH)) u_div_x (
    .clk_i  (clk_i),
    .val_i  (x_val),
    .cell_o (x_cell)
  );

  tgbc_cdiv #(.TILE_PITCH(TILE_PITCH)) u_div_y (
    .clk_i  (clk_i),
    .val_i  (y_val),
    .cell_o (y_cell)
  );

  // divide op tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
      div_op_q   <= DIV_SNAP;
    end else begin
      div_pend_q <= cmd_i.div_go;
      div_op_q   <= cmd_i.div_op;
    end
  end

  // snapped corner and covered cell span per axis
  always_ff @(posedge clk_i) begin
    if (div_pend_q) begin
      case (div_op_q)
        DIV_SNAP: begin
          cx_q <= x_cell;
          cy_q <= y_cell;
        end
        DIV_LO: begin
          lox_q <= x_cell;
          loy_q <= y_cell;
        end
        DIV_HI: begin
          hix_q <= x_cell;
          hiy_q <= y_cell;
        end
        default: begin
        end
      endcase
    end
  end

  // search window clipped to the grid and to the cells the box covers
  always_comb begin
    xs    = smax(smax(cx_q - DIV_OUT_W'(LOOK_X), '0), lox_q);
    xe    = smin(smin(cx_q + DIV_OUT_W'(LOOK_X), DIV_OUT_W'(MAP_WIDTH - 1)), hix_q);
    ys    = smax(smax(cy_q - DIV_OUT_W'(LOOK_Y), '0), loy_q);
    ye    = smin(smin(cy_q + DIV_OUT_W'(LOOK_Y), DIV_OUT_W'(MAP_HEIGHT - 1)), hiy_q);
    empty = (xs > xe) || (ys > ye);
  end

  // scan position over the window, row by row
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      xs_q <= xs[XW-1:0];
      xe_q <= xe[XW-1:0];
      ye_q <= ye[YW-1:0];
      x_q  <= xs[XW-1:0];
      y_q  <= ys[YW-1:0];
    end else if (cmd_i.ram_op == RAM_READ_SCAN) begin
      if (x_q == xe_q) begin
        x_q <= xs_q;
        y_q <= y_q + YW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.ram_op == RAM_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // tile memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cell_addr;
    ram_wdata = item_q.tile_kind;
    case (cmd_i.ram_op)
      RAM_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      RAM_WRITE: begin
        ram_we = cell_ok;
      end
      RAM_READ_CELL: begin
        ram_re = cell_ok;
      end
      RAM_READ_SCAN: begin
        ram_re   = 1'b1;
        ram_addr = {y_q, x_q};
      end
      default: begin
      end
    endcase
  end

  tgbc_ram #(.WIDTH(KIND_W), .DEPTH(DEPTH)) u_tiles (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // marks read data that belongs to the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= 1'b0;
    end else begin
      chk_q <= (cmd_i.ram_op == RAM_READ_SCAN);
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd_i.kind_cap) begin
        kind_q <= cell_ok ? ram_rdata : '0;
      end
      if (chk_q && (ram_rdata != '0)) begin
        hit_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_kind <= kind_q;
      out_q.hit       <= hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // status back to the controller
  assign sts_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign sts_o.win_empty = empty;
  assign sts_o.scan_last = (x_q == xe_q) && (y_q == ye_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[rtl/core/tgbc_ctrl.sv]
module tgbc_ctrl import tgbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  input  dp_sts_t    sts_i,
  output ctl_cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_WRITE: state_d = ST_WRITE;
            MODE_READ:  state_d = ST_READ;
            MODE_QUERY: state_d = ST_DIV_SNAP;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_WRITE:     state_d = ST_DONE;
      ST_READ:      state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_DONE;
      ST_DIV_SNAP:  state_d = ST_DIV_LO;
      ST_DIV_LO:    state_d = ST_DIV_HI;
      ST_DIV_HI:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  state_d = ST_WINDOW;
      ST_WINDOW: begin
        state_d = sts_i.win_empty ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:     state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.ram_op   = RAM_IDLE;
    cmd_o.div_op   = DIV_SNAP;
    unique case (state_q)
      ST_CLEAR: cmd_o.ram_op = RAM_CLEAR;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_WRITE:     cmd_o.ram_op = RAM_WRITE;
      ST_READ:      cmd_o.ram_op = RAM_READ_CELL;
      ST_READ_WAIT: cmd_o.kind_cap = 1'b1;
      ST_DIV_SNAP: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_SNAP;
      end
      ST_DIV_LO: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_LO;
      end
      ST_DIV_HI: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_HI;
      end
      ST_WINDOW:    cmd_o.win_load = 1'b1;
      ST_SCAN:      cmd_o.ram_op = RAM_READ_SCAN;
      ST_DONE:      cmd_o.out_load = sts_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/tile_grid_box_collision_unit.sv]
// Tile grid with box collision query. Holds a MAP_WIDTH x MAP_HEIGHT grid of
// 2-bit tile kinds in one single-port memory and returns exactly one result
// item per input item: a write stores a tile, a read returns a tile, and a
// collision query snaps the box corner to the nearest cell, scans the cells
// within two columns and one row of it that the box also covers, and flags a
// hit on any non-empty one. The scan reads one cell per cycle from the tile
// memory port. After reset a clearing pass writes every one of the
// MAP_HEIGHT * 2**clog2(MAP_WIDTH) memory entries (16384 at the default size)
// to empty, one per cycle, before the first item is taken. A finished result
// sits in an output register, so the next item is taken while it waits.
module tile_grid_box_collision_unit import tgbc_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int TILE_PITCH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer
  tgbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tile memory, divide units, scan and output register
  tgbc_dpath #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .TILE_PITCH (TILE_PITCH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

[rtl/core/tgbc_chk.sv]
module tgbc_chk import tgbc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_o
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("item taken while the previous one is in work");

  // at most one in work plus one waiting at the output
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many items outstanding");

  // no result without an item behind it
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("result delivered with no item outstanding");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

endmodule

bind tile_grid_box_collision_unit tgbc_chk u_chk (.*);

[test/tgbc_answer_checker.sv]
`timescale 1ns / 100ps

module tgbc_answer_checker import tgbc_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int TILE_PITCH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_i,
  output int        mismatches_o,
  output int        outstanding_o,
  output int        checked_o,
  output int        queries_o,
  output int        hits_o
);

  localparam longint CELL_FIX = longint'(TILE_PITCH) * 256;

  // shadow copy of the tile memory
  logic [KIND_W-1:0] grid [MAP_WIDTH*MAP_HEIGHT];

  // answers still owed by the block, oldest first
  out_item_t answer_q [$];

  int mismatch_cnt;
  int check_cnt;
  int query_cnt;
  int hit_cnt;

  // nearest cell along one axis, exact ties go to the lower cell
  function automatic longint snap_to_cell(longint v);
    longint a;
    longint f;
    a = v / CELL_FIX;
    if ((v % CELL_FIX) != 0 && v < 0) a = a - 1;
    f = v - a * CELL_FIX;
    if (2 * f > CELL_FIX) a = a + 1;
    return a;
  endfunction

  // apply one item to the shadow grid and work out its answer
  function automatic out_item_t predict_answer(in_item_t it);
    out_item_t ans;
    longint l, t, w, h;
    longint x0, x1, y0, y1;
    longint cl, ct;
    ans = '0;
    case (it.mode)
      MODE_WRITE: begin
        if (it.cell_x < MAP_WIDTH && it.cell_y < MAP_HEIGHT)
          grid[it.cell_y * MAP_WIDTH + it.cell_x] = it.tile_kind;
      end
      MODE_READ: begin
        if (it.cell_x < MAP_WIDTH && it.cell_y < MAP_HEIGHT)
          ans.read_kind = grid[it.cell_y * MAP_WIDTH + it.cell_x];
      end
      MODE_QUERY: begin
        l = longint'($signed(it.box_left));
        t = longint'($signed(it.box_top));
        w = longint'(it.box_width);
        h = longint'(it.box_height);
        // window around the snapped corner, clipped to the grid
        x0 = snap_to_cell(l) - LOOK_X;
        x1 = snap_to_cell(l) + LOOK_X;
        y0 = snap_to_cell(t) - LOOK_Y;
        y1 = snap_to_cell(t) + LOOK_Y;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > MAP_WIDTH - 1) x1 = MAP_WIDTH - 1;
        if (y1 > MAP_HEIGHT - 1) y1 = MAP_HEIGHT - 1;
        for (longint y = y0; y <= y1; y++) begin
          for (longint x = x0; x <= x1; x++) begin
            cl = x * CELL_FIX;
            ct = y * CELL_FIX;
            // strict overlap with a solid cell
            if (grid[int'(y * MAP_WIDTH + x)] != '0 &&
                l < cl + CELL_FIX && l + w > cl &&
                t < ct + CELL_FIX && t + h > ct) ans.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // compare finished items, then record newly taken ones
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t want;
    out_item_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < MAP_WIDTH * MAP_HEIGHT; i++) grid[i] = '0;
      answer_q.delete();
      mismatch_cnt = 0;
      check_cnt    = 0;
      query_cnt    = 0;
      hit_cnt      = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
      queries_o     <= 0;
      hits_o        <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          $error("result item with no item outstanding");
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          check_cnt++;
          if (out_i.read_kind !== want.read_kind) begin
            $error("read_kind mismatch: expected %0d, actual %0d",
                   want.read_kind, out_i.read_kind);
            mismatch_cnt++;
          end
          if (out_i.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, out_i.hit);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = predict_answer(in_i);
        answer_q.push_back(fresh);
        if (in_i.mode == MODE_QUERY) begin
          query_cnt++;
          if (fresh.hit) hit_cnt++;
        end
      end
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= answer_q.size();
      checked_o     <= check_cnt;
      queries_o     <= query_cnt;
      hits_o        <= hit_cnt;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench import tgbc_pkg::*;;

  localparam int MAP_WIDTH    = 128;
  localparam int MAP_HEIGHT   = 128;
  localparam int TILE_PITCH   = 16;
  localparam int CELL_FIX     = TILE_PITCH * 256;
  localparam int RANDOM_ITEMS = 1375;
  localparam int QUIET_FROM   = RANDOM_ITEMS - 200;
  localparam int HOLD_AT      = 500;
  localparam int PAUSE_AT     = 900;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;

  // mode code the block treats as a no-op
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_GRASS  = 2'd1;
  localparam logic [1:0] KIND_DIRT   = 2'd2;
  localparam logic [1:0] KIND_STONE  = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic hold_req;
  logic quiet;
  int   items_sent;
  int   cycle_count = 0;

  int mismatches;
  int outstanding;
  int checked;
  int queries;
  int hits;

  tile_grid_box_collision_unit #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .TILE_PITCH(TILE_PITCH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  tgbc_answer_checker #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .TILE_PITCH(TILE_PITCH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .queries_o    (queries),
    .hits_o       (hits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, int x, int y, logic [1:0] kind,
                                         int l, int t, int w, int h);
    in_item_t it;
    it.mode       = mode;
    it.cell_x     = x[CELL_IDX_W-1:0];
    it.cell_y     = y[CELL_IDX_W-1:0];
    it.tile_kind  = kind;
    it.box_left   = l[COORD_W-1:0];
    it.box_top    = t[COORD_W-1:0];
    it.box_width  = w[SIZE_W-1:0];
    it.box_height = h[SIZE_W-1:0];
    return it;
  endfunction

  // mostly items aimed at two busy corners of the map, the rest anywhere
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    int hx;
    int hy;
    int far;
    it.cell_x     = 7'($urandom);
    it.cell_y     = 7'($urandom);
    it.tile_kind  = 2'($urandom);
    it.box_left   = 20'($urandom);
    it.box_top    = 20'($urandom);
    it.box_width  = 16'($urandom);
    it.box_height = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) it.mode = MODE_WRITE;
    else if (r < 58) it.mode = MODE_READ;
    else if (r < 95) it.mode = MODE_QUERY;
    else it.mode = MODE_UNUSED;
    far = $urandom_range(0, 1);
    hx  = far ? MAP_WIDTH - 12 + $urandom_range(0, 11) : $urandom_range(0, 11);
    hy  = far ? MAP_HEIGHT - 6 + $urandom_range(0, 5) : $urandom_range(0, 5);
    if ($urandom_range(0, 3) != 0) begin
      it.cell_x   = hx[CELL_IDX_W-1:0];
      it.cell_y   = hy[CELL_IDX_W-1:0];
      it.box_left = 20'(hx * CELL_FIX + int'($urandom_range(0, 3 * CELL_FIX - 1)) - CELL_FIX);
      it.box_top  = 20'(hy * CELL_FIX + int'($urandom_range(0, 3 * CELL_FIX - 1)) - CELL_FIX);
      if ($urandom_range(0, 3) != 0) begin
        it.box_width  = 16'($urandom_range(0, 2 * CELL_FIX));
        it.box_height = 16'($urandom_range(0, 2 * CELL_FIX));
      end
    end
    return it;
  endfunction

  // offer one item and hold it until taken
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // result side: random stalls, one long hold-off, none near the end
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    in_item_t it;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    hold_req   <= 1'b0;
    quiet      <= 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reads and writes at and beside the grid corners, every tile kind
    send_item(make_item(MODE_READ, 0, 0, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_WRITE, 0, 0, KIND_STONE, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 0, 0, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_WRITE, 127, 127, KIND_GRASS, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 127, 127, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_WRITE, 1, 0, KIND_DIRT, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 1, 0, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_WRITE, 1, 0, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 1, 0, KIND_EMPTY, 0, 0, 0, 0));
    // snapping ties and just past the tie
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, CELL_FIX / 2, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, CELL_FIX / 2 + 1, CELL_FIX / 2, 16, 16));
    // zero-size box inside a solid cell
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, 100, 100, 0, 0));
    // boxes that only touch a cell edge, and one just inside
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, CELL_FIX, 0, CELL_FIX, CELL_FIX));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, -CELL_FIX, 0, CELL_FIX, 100));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, -CELL_FIX + 1, 0, CELL_FIX, 100));
    // coordinate extremes: window clipped away, and clipped at the far corner
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, -524288, -524288, 65535, 65535));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, 524287, 524287, 65535, 65535));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, 127 * CELL_FIX, 127 * CELL_FIX, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, -CELL_FIX / 2, -CELL_FIX / 2,
                        65535, 65535));
    // no-op mode with noise in every field
    it = random_item();
    it.mode = MODE_UNUSED;
    send_item(it);
    send_item(make_item(MODE_WRITE, 126, 127, KIND_DIRT, 0, 0, 0, 0));
    send_item(make_item(MODE_READ, 126, 127, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_WRITE, 0, 0, KIND_EMPTY, 0, 0, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, KIND_EMPTY, -CELL_FIX / 2, -CELL_FIX / 2,
                        65535, 65535));

    // random part
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == QUIET_FROM) quiet <= 1'b1;
      // drain everything once before going on
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      if (n < QUIET_FROM && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      send_item(random_item());
    end

    // drain and settle
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);

    $display("sent %0d items over writes, reads, queries and no-ops; %0d results checked",
             items_sent, checked);
    $display("%0d collision queries, %0d of them hit a solid tile", queries, hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tgbc_pkg.sv
rtl/core/tgbc_ram.sv
rtl/core/tgbc_cdiv.sv
rtl/core/tgbc_dpath.sv
rtl/core/tgbc_ctrl.sv
rtl/core/tile_grid_box_collision_unit.sv
rtl/core/tgbc_chk.sv
test/tgbc_answer_checker.sv
test/testbench.sv
